FILE: rtl/sbda_pkg.sv
package sbda_pkg;

   localparam int VALUE_W  = 64;
   localparam int CHAR_W   = 7;
   localparam int DIGITS   = 20;
   localparam int BCD_W    = DIGITS * 4;
   localparam int BIT_CNT_W = $clog2(VALUE_W);
   localparam int REM_W    = $clog2(DIGITS + 1);

   localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture magnitude and sign, clear BCD
      logic dabble;     // one double-dabble step
      logic shift_dig;  // drop the top BCD digit
      logic out_sign;   // put '-' in the output register
      logic out_digit;  // put the top digit in the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic neg;
      logic top_zero;
      logic one_left;
   } status_type;

endpackage

FILE: rtl/signed_binary_to_decimal_ascii_top.sv
// Sequence: after accept, 64 dabble steps run; a '-' comes first when the
//   input is negative, then leading zero digits are dropped (20 BCD digits
//   less the digit count); digits then follow one per cycle while not stalled.
// Requests: a new one is taken only once the last digit sits in the output
//   register; the 64-step bit-serial double-dabble loop is the bulk of the work.
// Reset: synchronous, active high; controller idles and rsp_valid drops.
module signed_binary_to_decimal_ascii_top
   import sbda_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CHAR_W-1:0]        rsp_char_out,
   output logic                     rsp_last
);

   // Controller sequences: load -> 64 dabble steps -> optional '-' ->
   // drop leading zero digits -> emit digits MSD first through the
   // output register. The input side reopens as soon as the final
   // character sits in the output register.
   cmd_type    cmd;
   status_type status;

   sbda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: magnitude shifter, 20-digit BCD register, digit counter,
   // output character register. Most negative input negates to 2^63.
   sbda_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .value    ($unsigned(req_value)),
      .cmd      (cmd),
      .status   (status),
      .char_out (rsp_char_out),
      .last     (rsp_last)
   );

endmodule

FILE: rtl/sbda_datapath.sv
module sbda_datapath
   import sbda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [VALUE_W-1:0] value,
   input  cmd_type           cmd,
   output status_type        status,
   output logic [CHAR_W-1:0] char_out,
   output logic              last
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [BCD_W-1:0]   bcd_adj;
   logic [3:0]         top_dig;

   // add-3 correction, digits are independent
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign top_dig = bcd_ff[BCD_W-1 -: 4];

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         neg_in = value[VALUE_W-1];
         bin_in = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
         bcd_in = '0;
         rem_in = REM_W'(DIGITS);
      end else if (cmd.dabble) begin
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
      end else if (cmd.shift_dig) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         rem_in = rem_ff - REM_W'(1);
      end
      if (cmd.out_sign) begin
         char_in = CHAR_MINUS;
         last_in = 1'b0;
      end else if (cmd.out_digit) begin
         char_in = CHAR_ZERO + CHAR_W'(top_dig);
         last_in = (rem_ff == REM_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= 1'b0;
         rem_ff <= '0;
      end else begin
         neg_ff <= neg_in;
         rem_ff <= rem_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.neg      = neg_ff;
   assign status.top_zero = (top_dig == 4'd0);
   assign status.one_left = (rem_ff == REM_W'(1));
   assign char_out        = char_ff;
   assign last            = last_ff;

endmodule

FILE: rtl/sbda_ctrl.sv
module sbda_ctrl
   import sbda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 vld_ff, vld_in;
   logic                 slot_free;

   assign slot_free = !vld_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.dabble = 1'b1;
            cnt_in     = cnt_ff + BIT_CNT_W'(1);
            if (cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!status.neg) begin
               state_in = ST_SKIP;
            end else if (slot_free) begin
               cmd.out_sign = 1'b1;
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (status.top_zero && !status.one_left) begin
               cmd.shift_dig = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.out_digit = 1'b1;
               cmd.shift_dig = 1'b1;
               if (status.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.out_sign || cmd.out_digit) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

FILE: rtl/sbda_checker.sv
module sbda_checker
   import sbda_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [CHAR_W-1:0]        rsp_char_out,
   input logic                     rsp_last
);

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_last))
      else $error("rsp payload changed under stall");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out == CHAR_MINUS) ||
                    (rsp_char_out >= CHAR_ZERO && rsp_char_out <= CHAR_ZERO + CHAR_W'(9)))
      else $error("rsp character out of set");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_out == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged last");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after accept");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind signed_binary_to_decimal_ascii_top sbda_checker u_sbda_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_value    (req_value),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);
